>>> rtl/wfhsp_pkg.sv
package wfhsp_pkg;

    // frame control codes
    localparam logic [1:0] FT_MGMT = 2'd0;
    localparam logic [1:0] FT_CTRL = 2'd1;

    localparam logic [3:0] ST_ASSOC_REQ  = 4'd0;
    localparam logic [3:0] ST_PROBE_REQ  = 4'd4;
    localparam logic [3:0] ST_PROBE_RESP = 4'd5;
    localparam logic [3:0] ST_BEACON     = 4'd8;

    localparam logic [7:0] EID_SSID = 8'd0;

    // header layout (byte offsets)
    localparam int HDR_BYTES      = 24;
    localparam int MIN_CTRL_BYTES = 10;
    localparam int CTRL_SRC_BYTES = 16;
    // last fixed-field byte before the tagged elements
    localparam int FIXED_END_DEF  = 23;
    localparam int FIXED_END_ASSOC = 27;
    localparam int FIXED_END_BEACON = 35;

    // ssid storage: 8-byte rows, two banks so one frame drains while the next fills
    localparam int SSID_MAX_BYTES = 32;
    localparam int SSID_ROWS      = 4;
    localparam int SSID_RAM_DEPTH = 2 * SSID_ROWS;
    localparam int SSID_RAM_AW    = 3;

    localparam logic [1:0] REC_SUMMARY = 2'd0;
    localparam logic [1:0] REC_ADDR    = 2'd1;
    localparam logic [1:0] REC_SSID    = 2'd2;

    localparam logic [1:0] ROLE_DST  = 2'd0;
    localparam logic [1:0] ROLE_SRC  = 2'd1;
    localparam logic [1:0] ROLE_BSS  = 2'd2;

    // record index within a frame's output: 0 summary, 1..3 addresses, 4..7 ssid
    localparam logic [2:0] IDX_SUMMARY = 3'd0;
    localparam logic [2:0] IDX_DST     = 3'd1;
    localparam logic [2:0] IDX_SRC     = 3'd2;
    localparam logic [2:0] IDX_BSS     = 3'd3;

    typedef enum logic [7:0] {
        PH_FIXED     = 8'b0000_0001,
        PH_TAG_ID    = 8'b0000_0010,
        PH_LEN_SSID  = 8'b0000_0100,
        PH_LEN_OTHER = 8'b0000_1000,
        PH_SKIP      = 8'b0001_0000,
        PH_SSID      = 8'b0010_0000,
        PH_FOUND     = 8'b0100_0000,
        PH_STOP      = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        logic [1:0]  ftype;
        logic [3:0]  subtype;
        logic        retry;
        logic [15:0] duration;
        logic [11:0] seq;
        logic [11:0] len;
        logic [5:0]  slen;
        logic [47:0] dst;
        logic [47:0] src;
        logic [47:0] bss;
        logic        bank;
        logic [2:0]  last_idx;
    } frame_sum_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  ftype;
        logic [3:0]  subtype;
        logic        retry;
        logic [15:0] duration;
        logic [11:0] seq;
        logic [11:0] len;
        logic [5:0]  slen;
        logic [1:0]  role;
        logic [63:0] value;
        logic        last;
    } out_rec_t;

endpackage

>>> rtl/wfhsp_ram.sv
module wfhsp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/wifi_frame_header_ssid_parser.sv
// channel  | dir | bits                              | word
// s_axis   | in  | tdata[7:0] frame_byte, tlast      | one frame byte
// m_axis   | out | tdata[118:0] fields, tuser kind,  | one record (summary, address
//          |     | tlast last_of_frame               | or ssid chunk)
//
// Cycles: one byte per cycle in; header capture and tag walk finish in the accept cycle.
// A frame end queues 4 + ceil(ssid_length/8) records, drained one per cycle while m_axis_tready
// allows, from an output register; ssid chunks come from a two-bank ssid RAM (registered read).
// Stalls: a frame's last byte is held off (tready low) while the previous frame's
// records still drain; other bytes keep flowing, since they fill the other RAM bank.
// Reset: async, clears the position, walk phase and emitter; no clearing pass.
module wifi_frame_header_ssid_parser
    import wfhsp_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = 4096
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] frame_byte
    input  logic         s_axis_tlast,   // last_byte
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [1:0] frame_type, [5:2] frame_subtype, [6] retry_flag, [22:7] duration_value,
    // [34:23] sequence_number, [46:35] frame_length, [52:47] ssid_length,
    // [54:53] address_role, [118:55] record_value, [119] zero pad
    output logic [119:0] m_axis_tdata,
    output logic [1:0]   m_axis_tuser,   // [1:0] record_kind
    output logic         m_axis_tlast    // last_of_frame
);

    localparam int POS_W = $clog2(MAX_FRAME_BYTES);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_FRAME_BYTES - 1);

    // parser state
    logic [POS_W-1:0] pos_reg, pos_next;
    phase_t           phase_reg, phase_next;
    logic [15:0]      fc_reg, fc_next;
    logic [15:0]      dur_reg, dur_next;
    logic [15:0]      seq_reg, seq_next;
    logic [47:0]      dst_reg, dst_next;
    logic [47:0]      src_reg, src_next;
    logic [47:0]      bss_reg, bss_next;
    logic [7:0]       elem_left_reg, elem_left_next;
    logic [5:0]       ssid_taken_reg, ssid_taken_next;
    logic [5:0]       ssid_exp_reg, ssid_exp_next;
    logic [63:0]      ssid_word_reg, ssid_word_next;
    logic             wr_bank_reg, wr_bank_next;

    // emitter state
    logic             emit_busy_reg, emit_busy_next;
    logic [2:0]       rec_idx_reg, rec_idx_next;
    frame_sum_t       sum_reg, sum_next;
    logic             out_valid_reg, out_valid_next;
    out_rec_t         out_reg, out_next;

    logic                   s_accept;
    logic                   emit_start;
    logic                   out_load;
    logic                   ram_we;
    logic [SSID_RAM_AW-1:0] ram_waddr;
    logic [63:0]            ram_wdata;
    logic [SSID_RAM_AW-1:0] ram_raddr;
    logic [63:0]            ram_rdata;

    // a frame end needs the emitter free; mid-frame bytes never wait
    assign s_axis_tready = !(emit_busy_reg && s_axis_tlast);
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // ---------------------------------------------------------------- parser
    always_comb
    begin
        logic [7:0]       b;
        logic [POS_W-1:0] fixed_end;
        logic [4:0]       hidx;
        logic [4:0]       lane;
        logic [2:0]       slane;
        logic [5:0]       taken_inc;
        logic [63:0]      word;
        logic             sub_ok;
        logic [POS_W-1:0] len;
        logic [POS_W+11:0] len_ext;
        logic [1:0]       ftype;
        logic [5:0]       slen;
        logic [6:0]       slen_p7;
        logic             len_ok;

        b         = s_axis_tdata[7:0];
        hidx      = pos_reg[4:0];
        lane      = 5'd0;
        slane     = ssid_taken_reg[2:0];
        taken_inc = ssid_taken_reg + 6'd1;
        word      = ssid_word_reg;
        sub_ok    = 1'b0;
        len       = '0;
        len_ext   = '0;
        ftype     = 2'd0;
        slen      = 6'd0;
        slen_p7   = 7'd0;
        len_ok    = 1'b0;

        case (fc_reg[7:4]) inside
            ST_PROBE_RESP, ST_BEACON: fixed_end = POS_W'(FIXED_END_BEACON);
            ST_ASSOC_REQ:             fixed_end = POS_W'(FIXED_END_ASSOC);
            default:                  fixed_end = POS_W'(FIXED_END_DEF);
        endcase

        pos_next        = pos_reg;
        phase_next      = phase_reg;
        fc_next         = fc_reg;
        dur_next        = dur_reg;
        seq_next        = seq_reg;
        dst_next        = dst_reg;
        src_next        = src_reg;
        bss_next        = bss_reg;
        elem_left_next  = elem_left_reg;
        ssid_taken_next = ssid_taken_reg;
        ssid_exp_next   = ssid_exp_reg;
        ssid_word_next  = ssid_word_reg;
        wr_bank_next    = wr_bank_reg;
        ram_we          = 1'b0;
        ram_waddr       = {wr_bank_reg, ssid_taken_reg[4:3]};
        ram_wdata       = word;
        emit_start      = 1'b0;
        sum_next        = sum_reg;

        if (s_accept)
        begin
            if (pos_reg != POS_LAST)
            begin
                pos_next = pos_reg + POS_W'(1);

                // fixed header: every byte lands in its own lane, so no clear is needed
                if (pos_reg < POS_W'(HDR_BYTES))
                begin
                    if (hidx < 5'd2)
                    begin
                        fc_next[{hidx[0], 3'b000} +: 8] = b;
                    end
                    else if (hidx < 5'd4)
                    begin
                        dur_next[{hidx[0], 3'b000} +: 8] = b;
                    end
                    else if (hidx < 5'd10)
                    begin
                        lane = hidx - 5'd4;
                        dst_next[{lane[2:0], 3'b000} +: 8] = b;
                    end
                    else if (hidx < 5'd16)
                    begin
                        lane = hidx - 5'd10;
                        src_next[{lane[2:0], 3'b000} +: 8] = b;
                    end
                    else if (hidx < 5'd22)
                    begin
                        lane = hidx - 5'd16;
                        bss_next[{lane[2:0], 3'b000} +: 8] = b;
                    end
                    else
                    begin
                        seq_next[{hidx[0], 3'b000} +: 8] = b;
                    end
                end

                // tagged element walk
                unique case (phase_reg)
                    PH_FIXED:
                    begin
                        if (pos_reg == '0)
                        begin
                            // only management frames that carry elements are walked
                            sub_ok = (b[7:4] == ST_ASSOC_REQ) || (b[7:4] == ST_PROBE_REQ) ||
                                     (b[7:4] == ST_PROBE_RESP) || (b[7:4] == ST_BEACON);
                            if (!(b[3:2] == FT_MGMT && sub_ok))
                            begin
                                phase_next = PH_STOP;
                            end
                        end
                        else if (pos_reg >= fixed_end)
                        begin
                            phase_next = PH_TAG_ID;
                        end
                    end
                    PH_TAG_ID:
                    begin
                        phase_next = (b == EID_SSID) ? PH_LEN_SSID : PH_LEN_OTHER;
                    end
                    PH_LEN_SSID:
                    begin
                        if (b == 8'd0 || b > 8'(SSID_MAX_BYTES))
                        begin
                            phase_next = PH_STOP;
                        end
                        else
                        begin
                            ssid_exp_next   = b[5:0];
                            ssid_taken_next = 6'd0;
                            phase_next      = PH_SSID;
                        end
                    end
                    PH_LEN_OTHER:
                    begin
                        if (b == 8'd0)
                        begin
                            phase_next = PH_TAG_ID;
                        end
                        else
                        begin
                            elem_left_next = b;
                            phase_next     = PH_SKIP;
                        end
                    end
                    PH_SKIP:
                    begin
                        elem_left_next = elem_left_reg - 8'd1;
                        if (elem_left_reg == 8'd1)
                        begin
                            phase_next = PH_TAG_ID;
                        end
                    end
                    PH_SSID:
                    begin
                        // gather 8 bytes in a staging word, write a row when full or done
                        if (slane == 3'd0)
                        begin
                            word = {56'd0, b};
                        end
                        else
                        begin
                            word = ssid_word_reg | ({56'd0, b} << {slane, 3'b000});
                        end
                        ssid_word_next  = word;
                        ssid_taken_next = taken_inc;
                        ram_wdata       = word;
                        if (taken_inc >= ssid_exp_reg)
                        begin
                            phase_next = PH_FOUND;
                        end
                        ram_we = (slane == 3'd7) || (taken_inc >= ssid_exp_reg);
                    end
                    PH_FOUND, PH_STOP:
                    begin
                    end
                    default:
                    begin
                        phase_next = PH_STOP;
                    end
                endcase
            end
            else if (phase_reg != PH_FOUND)
            begin
                phase_next = PH_STOP;
            end

            if (s_axis_tlast)
            begin
                len     = pos_next;
                len_ext = {12'd0, len};
                ftype   = fc_next[3:2];
                len_ok  = (len >= POS_W'(MIN_CTRL_BYTES)) &&
                          (ftype == FT_CTRL || len >= POS_W'(HDR_BYTES));
                if (ftype != FT_CTRL && phase_next == PH_FOUND)
                begin
                    slen = ssid_exp_next;
                end
                slen_p7 = {1'b0, slen} + 7'd7;

                sum_next.ftype    = ftype;
                sum_next.subtype  = fc_next[7:4];
                sum_next.retry    = fc_next[11];
                sum_next.duration = dur_next;
                sum_next.seq      = (ftype == FT_CTRL) ? 12'd0 : seq_next[15:4];
                sum_next.len      = len_ext[11:0];
                sum_next.slen     = slen;
                sum_next.dst      = dst_next;
                sum_next.src      = (ftype == FT_CTRL && len < POS_W'(CTRL_SRC_BYTES)) ?
                                    48'd0 : src_next;
                sum_next.bss      = (ftype == FT_CTRL) ? 48'd0 : bss_next;
                sum_next.bank     = wr_bank_reg;
                sum_next.last_idx = IDX_BSS + slen_p7[5:3];

                emit_start = len_ok;
                if (len_ok)
                begin
                    wr_bank_next = !wr_bank_reg;
                end

                pos_next   = '0;
                phase_next = PH_FIXED;
            end
        end
    end

    // ---------------------------------------------------------------- emitter
    assign out_load = emit_busy_reg && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        emit_busy_next = emit_busy_reg;
        rec_idx_next   = rec_idx_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (out_load)
        begin
            out_valid_next    = 1'b1;
            out_next.ftype    = sum_reg.ftype;
            out_next.subtype  = sum_reg.subtype;
            out_next.retry    = sum_reg.retry;
            out_next.duration = sum_reg.duration;
            out_next.seq      = sum_reg.seq;
            out_next.len      = sum_reg.len;
            out_next.slen     = sum_reg.slen;
            out_next.last     = (rec_idx_reg == sum_reg.last_idx);
            out_next.role     = ROLE_DST;
            case (rec_idx_reg)
                IDX_SUMMARY:
                begin
                    out_next.kind  = REC_SUMMARY;
                    out_next.value = 64'd0;
                end
                IDX_DST:
                begin
                    out_next.kind  = REC_ADDR;
                    out_next.value = {16'd0, sum_reg.dst};
                end
                IDX_SRC:
                begin
                    out_next.kind  = REC_ADDR;
                    out_next.role  = ROLE_SRC;
                    out_next.value = {16'd0, sum_reg.src};
                end
                IDX_BSS:
                begin
                    out_next.kind  = REC_ADDR;
                    out_next.role  = ROLE_BSS;
                    out_next.value = {16'd0, sum_reg.bss};
                end
                default:
                begin
                    out_next.kind  = REC_SSID;
                    out_next.value = ram_rdata;
                end
            endcase

            if (rec_idx_reg == sum_reg.last_idx)
            begin
                emit_busy_next = 1'b0;
            end
            else
            begin
                rec_idx_next = rec_idx_reg + 3'd1;
            end
        end

        if (emit_start)
        begin
            emit_busy_next = 1'b1;
            rec_idx_next   = IDX_SUMMARY;
        end
    end

    // read one record ahead: rdata lines up with rec_idx_reg; chunk rows are idx 4..7
    assign ram_raddr = {sum_next.bank, rec_idx_next[1:0]};

    wfhsp_ram #(
        .WIDTH (64),
        .DEPTH (SSID_RAM_DEPTH)
    ) u_ssid_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ---------------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            phase_reg      <= PH_FIXED;
            elem_left_reg  <= 8'd0;
            ssid_taken_reg <= 6'd0;
            ssid_exp_reg   <= 6'd0;
            wr_bank_reg    <= 1'b0;
            emit_busy_reg  <= 1'b0;
            rec_idx_reg    <= IDX_SUMMARY;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pos_reg        <= pos_next;
            phase_reg      <= phase_next;
            elem_left_reg  <= elem_left_next;
            ssid_taken_reg <= ssid_taken_next;
            ssid_exp_reg   <= ssid_exp_next;
            wr_bank_reg    <= wr_bank_next;
            emit_busy_reg  <= emit_busy_next;
            rec_idx_reg    <= rec_idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fc_reg        <= fc_next;
        dur_reg       <= dur_next;
        seq_reg       <= seq_next;
        dst_reg       <= dst_next;
        src_reg       <= src_next;
        bss_reg       <= bss_next;
        ssid_word_reg <= ssid_word_next;
        sum_reg       <= sum_next;
        out_reg       <= out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tlast  = out_reg.last;
    assign m_axis_tdata  = {1'b0, out_reg.value, out_reg.role, out_reg.slen, out_reg.len,
                            out_reg.seq, out_reg.duration, out_reg.retry, out_reg.subtype,
                            out_reg.ftype};

    // ---------------------------------------------------------------- assertions
    // a new frame summary never lands on a frame still draining
    assert property (@(posedge clk) disable iff (!rst_n)
        emit_start |-> !emit_busy_reg)
        else $error("frame end accepted while emitter busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SSID) |-> (ssid_taken_reg < ssid_exp_reg))
        else $error("ssid byte count past element length");

    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_FOUND) |->
            (ssid_exp_reg != 6'd0 && ssid_exp_reg <= 6'(SSID_MAX_BYTES)))
        else $error("found ssid with bad length");

    assert property (@(posedge clk) disable iff (!rst_n)
        emit_busy_reg |-> (rec_idx_reg <= sum_reg.last_idx))
        else $error("record index ran past last record");

endmodule
